[hdl/gpf_pkg.sv]
package gpf_pkg;

  // Largest fill column the word memory is sized for by default.
  localparam int MAX_FILL_DEF = 62;

  localparam int CH_W  = 8;
  localparam int COL_W = 7;
  // Held word length; wide enough for the largest supported MAX_FILL.
  localparam int LEN_W = 6;
  localparam int FILL_W = 6;

  localparam logic [CH_W-1:0]   CH_SPACE = 8'd32;
  localparam logic [CH_W-1:0]   CH_TAB   = 8'd9;
  localparam logic [CH_W-1:0]   CH_BREAK = 8'd13;
  localparam logic [COL_W-1:0]  COL_MAX  = 7'd127;
  localparam logic [FILL_W-1:0] FILL_RESET = 6'd62;
  localparam logic [CH_W:0]     TAB_STEP = 9'd8;
  localparam logic [CH_W:0]     TAB_MASK = 9'h1F8;

  // One release job: optional separator, held word, optional tail beat.
  typedef struct packed {
    logic             has_sep;
    logic [CH_W-1:0]  sep_char;
    logic [LEN_W-1:0] word_len;
    logic             has_tail;
    logic [CH_W-1:0]  tail_char;
    logic             tail_last;
  } gpf_job_t;

endpackage

[hdl/gpf_if.sv]
interface gpf_in_if;
  logic                      valid;
  logic                      ready;
  logic [gpf_pkg::CH_W-1:0]  text_char;
  logic                      final_char;

  modport source (output valid, output text_char, output final_char, input ready);
  modport sink (input valid, input text_char, input final_char, output ready);
endinterface

interface gpf_out_if;
  logic                      valid;
  logic                      ready;
  logic [gpf_pkg::CH_W-1:0]  out_char;
  logic                      out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

[hdl/greedy_paragraph_fill.sv]
// Greedy paragraph filler. Characters of one paragraph arrive on the text
// channel, one per beat, with final_char set on the last one; the same
// characters leave on the wrapped channel in the same order, except that
// some spaces or tabs become carriage returns (13) so that lines stay within
// the fill column. The fill column is to be written through cfg_we/cfg_wdata
// only while the block is idle, which the block itself does not enforce;
// 0 acts as 1 and values above MAX_FILL act as MAX_FILL. A word character
// that can still move to the next line is held in a word memory of MAX_FILL
// entries and produces no beat on its own. A character that settles the
// pending word (whitespace, a word character that passes the fill column,
// finds the word memory full or follows a settled word, or the final
// character) starts a release: the held separator, then the held word read
// out of the memory, then the character itself where it goes out at once.
// The held word is read through the single read port of the word memory,
// whose read data is registered, and stalls on the output side hold the
// release back. All other characters are taken one per cycle. Input
// ready is low only while a release is in progress: a finished beat waiting
// in the output register does not hold back the next character. The last
// beat of a paragraph carries out_last. The word memory needs no clearing
// pass after reset, so the block takes characters right after reset.
module greedy_paragraph_fill #(
  parameter int MAX_FILL = gpf_pkg::MAX_FILL_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [gpf_pkg::FILL_W-1:0] cfg_wdata,
  gpf_in_if.sink                     text,
  gpf_out_if.source                  wrapped
);

  localparam int AW = $clog2(MAX_FILL);
  localparam logic [gpf_pkg::FILL_W-1:0] FILL_LIMIT = gpf_pkg::FILL_W'(MAX_FILL);
  localparam logic [gpf_pkg::LEN_W-1:0]  LEN_LIMIT  = gpf_pkg::LEN_W'(MAX_FILL);

  // Paragraph state.
  logic [gpf_pkg::FILL_W-1:0] fill_column;
  logic [gpf_pkg::COL_W-1:0]  column;
  logic [gpf_pkg::COL_W-1:0]  column_next;
  logic [gpf_pkg::LEN_W-1:0]  word_length;
  logic [gpf_pkg::LEN_W-1:0]  word_length_next;
  logic [gpf_pkg::CH_W-1:0]   separator_char;
  logic [gpf_pkg::CH_W-1:0]   separator_char_next;
  logic                       separator_present;
  logic                       separator_present_next;
  logic                       word_decided;
  logic                       word_decided_next;

  logic                       accept;
  logic                       busy;
  logic                       start;
  gpf_pkg::gpf_job_t          job;
  logic [gpf_pkg::CH_W-1:0]   c;
  logic                       fin;
  logic                       is_ws;
  logic [gpf_pkg::COL_W-1:0]  fill_eff;
  logic [gpf_pkg::CH_W:0]     ws_sum;
  logic [gpf_pkg::COL_W-1:0]  ws_col;
  logic                       ws_break;
  logic [gpf_pkg::CH_W-1:0]   sep_new;
  logic [gpf_pkg::COL_W-1:0]  char_col;
  logic                       char_over;
  logic                       store_path;
  logic                       release_word;
  logic                       mem_we;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [gpf_pkg::CH_W-1:0]   rd_data;

  assign c          = text.text_char;
  assign fin        = text.final_char;
  assign accept     = text.valid && text.ready;
  assign text.ready = !busy;
  assign is_ws      = (c == gpf_pkg::CH_SPACE) || (c == gpf_pkg::CH_TAB);

  // Clamp the programmed fill column into the supported range.
  always_comb begin
    if (fill_column == '0) begin
      fill_eff = 7'd1;
    end else if (fill_column > FILL_LIMIT) begin
      fill_eff = {1'b0, FILL_LIMIT};
    end else begin
      fill_eff = {1'b0, fill_column};
    end
  end

  // Column after whitespace: a tab goes to the next multiple of eight, and
  // the column saturates at its largest value.
  always_comb begin
    if (c == gpf_pkg::CH_TAB) begin
      ws_sum = ({2'b00, column} + gpf_pkg::TAB_STEP) & gpf_pkg::TAB_MASK;
    end else begin
      ws_sum = {2'b00, column} + 9'd1;
    end
    if (ws_sum > {2'b00, gpf_pkg::COL_MAX}) begin
      ws_col = gpf_pkg::COL_MAX;
    end else begin
      ws_col = ws_sum[gpf_pkg::COL_W-1:0];
    end
  end

  assign ws_break  = ws_col > fill_eff;
  assign sep_new   = ws_break ? gpf_pkg::CH_BREAK : c;
  assign char_col  = (column < gpf_pkg::COL_MAX) ? column + 7'd1 : column;
  assign char_over = char_col > fill_eff;

  // A word character that still fits and may yet move is held in memory.
  assign store_path   = !is_ws && !word_decided && !char_over && (word_length < LEN_LIMIT);
  assign release_word = !store_path || fin;
  assign mem_we       = accept && store_path && !fin;

  always_comb begin
    column_next            = column;
    word_length_next       = word_length;
    separator_char_next    = separator_char;
    separator_present_next = separator_present;
    word_decided_next      = word_decided;

    job.has_sep   = release_word && separator_present;
    job.sep_char  = separator_char;
    job.word_len  = release_word ? word_length : '0;
    job.has_tail  = (!is_ws && !store_path) || fin;
    job.tail_char = c;
    job.tail_last = fin;

    if (is_ws) begin
      job.tail_char          = sep_new;
      column_next            = ws_break ? '0 : ws_col;
      separator_char_next    = sep_new;
      separator_present_next = 1'b1;
      word_length_next       = '0;
      word_decided_next      = 1'b0;
    end else begin
      column_next = char_col;
      if (store_path) begin
        word_length_next = word_length + 1'b1;
      end else if (!word_decided) begin
        // The word is settled. If it passes the fill column it moves to a new
        // line: its separator becomes the break, unless it is one already or there is none.
        if (char_over && separator_present && separator_char != gpf_pkg::CH_BREAK) begin
          job.sep_char        = gpf_pkg::CH_BREAK;
          separator_char_next = gpf_pkg::CH_BREAK;
          column_next         = {1'b0, word_length} + 7'd1;
        end
        word_length_next       = '0;
        separator_present_next = 1'b0;
        word_decided_next      = 1'b1;
      end
    end

    if (fin) begin
      column_next            = '0;
      word_length_next       = '0;
      separator_char_next    = '0;
      separator_present_next = 1'b0;
      word_decided_next      = 1'b0;
    end
  end

  assign start = accept && (job.has_sep || job.word_len != '0 || job.has_tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_column       <= gpf_pkg::FILL_RESET;
      column            <= '0;
      word_length       <= '0;
      separator_char    <= '0;
      separator_present <= 1'b0;
      word_decided      <= 1'b0;
    end else begin
      if (cfg_we) begin
        fill_column <= cfg_wdata;
      end
      if (accept) begin
        column            <= column_next;
        word_length       <= word_length_next;
        separator_char    <= separator_char_next;
        separator_present <= separator_present_next;
        word_decided      <= word_decided_next;
      end
    end
  end

  gpf_word_mem #(
    .DEPTH (MAX_FILL),
    .AW    (AW)
  ) u_word_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (word_length[AW-1:0]),
    .wr_data (c),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gpf_emit #(
    .MAX_FILL (MAX_FILL),
    .AW       (AW)
  ) u_emit (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .job     (job),
    .busy    (busy),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wrapped (wrapped)
  );

endmodule

[hdl/gpf_word_mem.sv]
module gpf_word_mem #(
  parameter int DEPTH = gpf_pkg::MAX_FILL_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [gpf_pkg::CH_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic [gpf_pkg::CH_W-1:0] rd_data
);

  logic [gpf_pkg::CH_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/gpf_emit.sv]
module gpf_emit #(
  parameter int MAX_FILL = gpf_pkg::MAX_FILL_DEF,
  parameter int AW       = $clog2(MAX_FILL)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  gpf_pkg::gpf_job_t        job,
  output logic                     busy,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  logic [gpf_pkg::CH_W-1:0] rd_data,
  gpf_out_if.source                wrapped
);

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_SEP  = 4'b0010,
    E_WORD = 4'b0100,
    E_TAIL = 4'b1000
  } gpf_emit_st_t;

  gpf_emit_st_t              state;
  gpf_emit_st_t              state_next;
  gpf_pkg::gpf_job_t         job_q;
  logic [gpf_pkg::LEN_W-1:0] rd_idx;
  logic                      pend;
  logic                      pend_next;
  logic                      out_valid;
  logic [gpf_pkg::CH_W-1:0]  out_char;
  logic                      out_last;
  logic                      slot_free;
  logic                      load;
  logic [gpf_pkg::CH_W-1:0]  load_char;
  logic                      load_last;
  logic                      word_done;

  assign slot_free        = !out_valid || wrapped.ready;
  assign busy             = (state != E_IDLE);
  assign rd_addr          = rd_idx[AW-1:0];
  assign wrapped.valid    = out_valid;
  assign wrapped.out_char = out_char;
  assign wrapped.out_last = out_last;

  always_comb begin
    state_next = state;
    load       = 1'b0;
    load_char  = job_q.sep_char;
    load_last  = 1'b0;
    rd_en      = 1'b0;
    word_done  = 1'b0;
    case (state)
      E_IDLE: begin
        if (start) begin
          if (job.has_sep) begin
            state_next = E_SEP;
          end else if (job.word_len != '0) begin
            state_next = E_WORD;
          end else begin
            state_next = E_TAIL;
          end
        end
      end
      E_SEP: begin
        if (slot_free) begin
          load = 1'b1;
          if (job_q.word_len != '0) begin
            state_next = E_WORD;
          end else if (job_q.has_tail) begin
            state_next = E_TAIL;
          end else begin
            state_next = E_IDLE;
          end
        end
      end
      E_WORD: begin
        // Reads run one entry ahead of the output register.
        load      = pend && slot_free;
        load_char = rd_data;
        rd_en     = (rd_idx != job_q.word_len) && (!pend || load);
        word_done = (rd_idx == job_q.word_len) && (!pend || load);
        if (word_done) begin
          state_next = job_q.has_tail ? E_TAIL : E_IDLE;
        end
      end
      E_TAIL: begin
        if (slot_free) begin
          load       = 1'b1;
          load_char  = job_q.tail_char;
          load_last  = job_q.tail_last;
          state_next = E_IDLE;
        end
      end
      default: begin
        state_next = E_IDLE;
      end
    endcase
  end

  always_comb begin
    pend_next = pend;
    if (rd_en) begin
      pend_next = 1'b1;
    end else if (load && state == E_WORD) begin
      pend_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      pend      <= 1'b0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == E_IDLE && start) begin
        rd_idx <= '0;
        pend   <= 1'b0;
      end else begin
        pend <= pend_next;
        if (rd_en) begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (wrapped.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_IDLE && start) begin
      job_q <= job;
    end
    if (load) begin
      out_char <= load_char;
      out_last <= load_last;
    end
  end

endmodule

[hdl/gpf_checker.sv]
module gpf_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_final,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [gpf_pkg::CH_W-1:0] out_char,
  input logic                     out_last
);

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present after reset");

  // A final character always releases at least one beat, so input stalls.
  a_final_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_final |=> !in_ready)
    else $error("input not stalled after final character");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_char) && $stable(out_last))
    else $error("output payload changed while stalled");

endmodule

bind greedy_paragraph_fill gpf_checker u_gpf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text.valid),
  .in_ready  (text.ready),
  .in_final  (text.final_char),
  .out_valid (wrapped.valid),
  .out_ready (wrapped.ready),
  .out_char  (wrapped.out_char),
  .out_last  (wrapped.out_last)
);

[bench/greedy_paragraph_fill_tb.sv]
`timescale 1ns / 100ps

module greedy_paragraph_fill_tb;

  // Generous bound on the whole run. The slowest legal run is about a
  // hundred and thirty characters, each releasing at most 64 beats under
  // the heaviest stalls.
  localparam int CYCLE_LIMIT = 200000;
  // Cycles to let pass once every expected beat has arrived, so that the
  // block is surely idle before the fill column is changed.
  localparam int SETTLE_CYCLES = 16;

  // One character on the text channel and one beat on the wrapped channel.
  typedef struct packed {
    logic [gpf_pkg::CH_W-1:0] ch;
    logic                     fin;
  } text_beat_t;

  typedef struct packed {
    logic [gpf_pkg::CH_W-1:0] ch;
    logic                     last;
  } wrap_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [gpf_pkg::FILL_W-1:0] cfg_wdata = '0;

  gpf_in_if  text();
  gpf_out_if wrapped();

  greedy_paragraph_fill dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .text     (text),
    .wrapped  (wrapped)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Characters waiting to be sent, and the wrapped beats that the accepted
  // characters are predicted to produce, oldest first.
  text_beat_t text_pending[$];
  wrap_beat_t wrapped_expect[$];

  // Percentages of cycles in which the sender holds back a character and
  // the receiver refuses a beat.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // The filler as this bench sees it: fill column register, current line
  // column, the held word and the separator in front of it.
  logic [gpf_pkg::FILL_W-1:0] fill_reg = gpf_pkg::FILL_RESET;
  logic [gpf_pkg::COL_W-1:0]  line_col = '0;
  logic [gpf_pkg::CH_W-1:0]   word_buf [gpf_pkg::MAX_FILL_DEF];
  logic [gpf_pkg::LEN_W-1:0]  word_len = '0;
  logic [gpf_pkg::CH_W-1:0]   sep_ch = '0;
  logic                       sep_held = 1'b0;
  logic                       word_settled = 1'b0;

  wrap_beat_t got_want;

  task automatic expect_beat(input logic [gpf_pkg::CH_W-1:0] ch);
    wrap_beat_t b;
    b.ch = ch;
    b.last = 1'b0;
    wrapped_expect.push_back(b);
  endtask

  // Let the held separator and word go out, in that order.
  task automatic flush_held();
    if (sep_held) begin
      expect_beat(sep_ch);
    end
    for (int i = 0; i < word_len; i++) begin
      expect_beat(word_buf[i]);
    end
    word_len = '0;
    sep_held = 1'b0;
  endtask

  // Advance the filler by one accepted character and queue the beats it
  // releases.
  task automatic fold_char(input logic [gpf_pkg::CH_W-1:0] ch, input logic fin);
    int fill;
    int col;
    int first;
    wrap_beat_t tail;
    // The register is clamped: zero behaves as one, anything past the
    // word memory size behaves as the largest fill.
    fill = (fill_reg == 0) ? 1 :
           ((fill_reg > gpf_pkg::MAX_FILL_DEF) ? gpf_pkg::MAX_FILL_DEF : int'(fill_reg));
    first = wrapped_expect.size();
    col = int'(line_col);
    if (ch == gpf_pkg::CH_SPACE || ch == gpf_pkg::CH_TAB) begin
      // Whitespace closes the pending word, so everything held goes out.
      flush_held();
      if (ch == gpf_pkg::CH_TAB) begin
        col = (col + 8) & ~7;
      end else begin
        col = col + 1;
      end
      if (col > gpf_pkg::COL_MAX) begin
        col = gpf_pkg::COL_MAX;
      end
      sep_ch = ch;
      // Whitespace that runs past the fill column is itself the break.
      if (col > fill) begin
        sep_ch = gpf_pkg::CH_BREAK;
        col = 0;
      end
      sep_held = 1'b1;
      word_settled = 1'b0;
    end else begin
      if (col < gpf_pkg::COL_MAX) begin
        col = col + 1;
      end
      if (word_settled) begin
        expect_beat(ch);
      end else if (col > fill) begin
        // The word does not fit: its separator turns into the break unless
        // it already is one or the word opens the text.
        if (sep_held && sep_ch != gpf_pkg::CH_BREAK) begin
          sep_ch = gpf_pkg::CH_BREAK;
          col = int'(word_len) + 1;
        end
        flush_held();
        expect_beat(ch);
        word_settled = 1'b1;
      end else if (word_len < gpf_pkg::MAX_FILL_DEF) begin
        word_buf[word_len] = ch;
        word_len = word_len + 1'b1;
      end else begin
        flush_held();
        expect_beat(ch);
        word_settled = 1'b1;
      end
    end
    line_col = gpf_pkg::COL_W'(col);
    if (fin) begin
      // End of paragraph: drain everything, flag the final beat and start
      // the next paragraph from a clean line. The fill column stays.
      flush_held();
      if (wrapped_expect.size() > first) begin
        tail = wrapped_expect.pop_back();
        tail.last = 1'b1;
        wrapped_expect.push_back(tail);
      end
      line_col = '0;
      word_len = '0;
      sep_ch = '0;
      sep_held = 1'b0;
      word_settled = 1'b0;
    end
  endtask

  // Driver. A character is accepted at an edge where valid and ready are
  // both high; only then is it folded into the prediction. A new beat is
  // offered when the channel is free, unless the sender chooses to idle.
  always @(posedge clk) begin
    if (rst) begin
      text.valid <= 1'b0;
      text.text_char <= '0;
      text.final_char <= 1'b0;
    end else begin
      if (text.valid && text.ready) begin
        fold_char(text.text_char, text.final_char);
      end
      if (!text.valid || text.ready) begin
        if (text_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          text.valid <= 1'b1;
          text.text_char <= text_pending[0].ch;
          text.final_char <= text_pending[0].fin;
          void'(text_pending.pop_front());
        end else begin
          text.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every accepted beat on the wrapped channel is matched against
  // the oldest prediction; ready is redrawn every cycle.
  always @(posedge clk) begin
    if (rst) begin
      wrapped.ready <= 1'b0;
    end else begin
      if (wrapped.valid && wrapped.ready) begin
        if (wrapped_expect.size() == 0) begin
          $error("unexpected beat: out_char %0d out_last %0d",
                 wrapped.out_char, wrapped.out_last);
          fail_count++;
        end else begin
          got_want = wrapped_expect.pop_front();
          if (wrapped.out_char !== got_want.ch) begin
            $error("out_char: expected %0d, got %0d", got_want.ch, wrapped.out_char);
            fail_count++;
          end
          if (wrapped.out_last !== got_want.last) begin
            $error("out_last: expected %0d, got %0d", got_want.last, wrapped.out_last);
            fail_count++;
          end
        end
      end
      wrapped.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hung channel or a lost beat ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_char(input logic [gpf_pkg::CH_W-1:0] ch);
    text_beat_t b;
    b.ch = ch;
    b.fin = 1'b0;
    text_pending.push_back(b);
  endtask

  task automatic queue_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_char(s[i]);
    end
  endtask

  // Mark the most recently queued character as the end of its paragraph.
  task automatic close_paragraph();
    text_beat_t b;
    b = text_pending.pop_back();
    b.fin = 1'b1;
    text_pending.push_back(b);
  endtask

  // Mostly lowercase letters, sometimes any byte that is not whitespace.
  function automatic logic [gpf_pkg::CH_W-1:0] word_char();
    logic [gpf_pkg::CH_W-1:0] c;
    if ($urandom_range(3) != 0) begin
      c = 8'h61 + gpf_pkg::CH_W'($urandom_range(25));
    end else begin
      c = gpf_pkg::CH_W'($urandom_range(255));
      if (c == gpf_pkg::CH_SPACE || c == gpf_pkg::CH_TAB) begin
        c = 8'h2D;
      end
    end
    return c;
  endfunction

  // A paragraph of random words and separators. Most separators are single
  // spaces; tabs, doubled whitespace and stray bytes of any value break the
  // regular shape now and then.
  task automatic add_random_paragraph(input int n_chars, input int word_max);
    int k;
    int wlen;
    k = 0;
    if ($urandom_range(4) == 0) begin
      queue_char(gpf_pkg::CH_SPACE);
      k++;
    end
    while (k < n_chars) begin
      wlen = $urandom_range(word_max, 1);
      for (int i = 0; i < wlen && k < n_chars; i++) begin
        queue_char(word_char());
        k++;
      end
      if (k < n_chars) begin
        case ($urandom_range(9))
          0: queue_char(gpf_pkg::CH_W'($urandom_range(255)));
          1, 2: queue_char(gpf_pkg::CH_TAB);
          3: begin
            queue_char(gpf_pkg::CH_SPACE);
            queue_char(gpf_pkg::CH_TAB);
            k++;
          end
          default: queue_char(gpf_pkg::CH_SPACE);
        endcase
        k++;
      end
    end
    close_paragraph();
  endtask

  // The fill column may only change while nothing is in flight.
  task automatic write_fill(input logic [gpf_pkg::FILL_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    fill_reg = value;
  endtask

  // Wait until every queued character has been taken and every predicted
  // beat has come out, then let the block settle into idle.
  task automatic wait_drained();
    while (text_pending.size() != 0 || text.valid || wrapped_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    text.valid = 1'b0;
    text.text_char = '0;
    text.final_char = 1'b0;
    wrapped.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Sender idles a third of the time, receiver stalls about half.
    send_idle_pct = 33;
    recv_stall_pct = 55;

    // Directed paragraph at a narrow fill: the byte extremes and a carriage
    // return as plain word characters, a tab, a word that pushes its tab
    // into a break, whitespace that runs past the fill column, and a long
    // word behind a plain space. It ends on whitespace.
    write_fill(6'd10);
    queue_char(8'h00);
    queue_char(8'hFF);
    queue_char(gpf_pkg::CH_SPACE);
    queue_char(gpf_pkg::CH_BREAK);
    queue_char(gpf_pkg::CH_TAB);
    queue_string("abcdefg");
    queue_char(gpf_pkg::CH_SPACE);
    queue_char(gpf_pkg::CH_TAB);
    queue_char(gpf_pkg::CH_SPACE);
    queue_string("hijklmnopqr");
    queue_char(gpf_pkg::CH_SPACE);
    close_paragraph();
    // A paragraph of a single character.
    queue_char(8'h7A);
    close_paragraph();
    wait_drained();

    // Zero fill column behaves as one: every word breaks its line.
    write_fill(6'd0);
    add_random_paragraph(8, 4);
    wait_drained();

    // Swap the idling of the two sides.
    send_idle_pct = 55;
    recv_stall_pct = 33;

    // All ones in the register: clamped to the widest fill.
    write_fill(6'h3F);
    add_random_paragraph(12, 9);
    wait_drained();

    write_fill(gpf_pkg::FILL_W'($urandom_range(61, 2)));
    add_random_paragraph(8, 3);
    wait_drained();

    // Full rate on both sides from here on.
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // Widest fill: tabs run the line past the fill column so the last one
    // becomes a break, then a word that fills the whole word memory and one
    // more character releases the largest burst the block can produce.
    write_fill(6'd62);
    repeat (8) queue_char(gpf_pkg::CH_TAB);
    repeat (63) queue_char(word_char());
    close_paragraph();
    wait_drained();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/gpf_pkg.sv
hdl/gpf_if.sv
hdl/gpf_word_mem.sv
hdl/gpf_emit.sv
hdl/greedy_paragraph_fill.sv
hdl/gpf_checker.sv
bench/greedy_paragraph_fill_tb.sv
